// ===== design/c_token_scanner_assert.svh =====
// Assertion macros used by the checker file of the token scanner.
// Depends on nothing; include by bare file name.
`ifndef C_TOKEN_SCANNER_ASSERT_SVH
`define C_TOKEN_SCANNER_ASSERT_SVH
`define CTS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== design/cts_pkg.sv =====
// Package of the token scanner: kinds, scan modes and character tables.
// Depends on nothing.
`default_nettype none
package cts_pkg;
  localparam int unsigned OffsetBitsDef   = 32;
  localparam int unsigned PositionBitsDef = 20;
  localparam int unsigned LengthBitsDef   = 16;

  localparam logic [3:0] M_IDLE       = 4'd0;
  localparam logic [3:0] M_IDENT      = 4'd1;
  localparam logic [3:0] M_NUMBER     = 4'd2;
  localparam logic [3:0] M_STRING     = 4'd3;
  localparam logic [3:0] M_STR_ESC    = 4'd4;
  localparam logic [3:0] M_CHAR_OPEN  = 4'd5;
  localparam logic [3:0] M_CHAR_ESC   = 4'd6;
  localparam logic [3:0] M_CHAR_CLOSE = 4'd7;
  localparam logic [3:0] M_OPER       = 4'd8;
  localparam logic [3:0] M_LINE_COM   = 4'd9;
  localparam logic [3:0] M_BLOCK_COM  = 4'd10;
  localparam logic [3:0] M_BLOCK_STAR = 4'd11;

  localparam logic [5:0] K_EOF     = 6'd0;
  localparam logic [5:0] K_UNKNOWN = 6'd1;
  localparam logic [5:0] K_IDENT   = 6'd2;
  localparam logic [5:0] K_KW0     = 6'd3;
  localparam logic [5:0] K_INT     = 6'd18;
  localparam logic [5:0] K_STRING  = 6'd19;
  localparam logic [5:0] K_CHAR    = 6'd20;
  localparam logic [5:0] K_PAIR0   = 6'd21;
  localparam logic [5:0] K_SINGLE0 = 6'd35;

  localparam logic [7:0] CH_LF = 8'h0A;

  function automatic logic is_alpha(logic [7:0] c);
    return c == "_" || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == " " || c == 8'h09 || c == 8'h0D || c == CH_LF;
  endfunction

  function automatic logic is_op_start(logic [7:0] c);
    return c == "=" || c == "!" || c == "<" || c == ">" || c == "+" ||
           c == "-" || c == "&" || c == "|" || c == "#" || c == "/";
  endfunction

  function automatic logic [5:0] single_kind(logic [7:0] c);
    logic [5:0] k;
    case (c)
      "+": k = K_SINGLE0 + 6'd0;
      "-": k = K_SINGLE0 + 6'd1;
      "*": k = K_SINGLE0 + 6'd2;
      "/": k = K_SINGLE0 + 6'd3;
      "%": k = K_SINGLE0 + 6'd4;
      "=": k = K_SINGLE0 + 6'd5;
      "<": k = K_SINGLE0 + 6'd6;
      ">": k = K_SINGLE0 + 6'd7;
      "&": k = K_SINGLE0 + 6'd8;
      "|": k = K_SINGLE0 + 6'd9;
      "^": k = K_SINGLE0 + 6'd10;
      "!": k = K_SINGLE0 + 6'd11;
      "?": k = K_SINGLE0 + 6'd12;
      ":": k = K_SINGLE0 + 6'd13;
      ";": k = K_SINGLE0 + 6'd14;
      ",": k = K_SINGLE0 + 6'd15;
      ".": k = K_SINGLE0 + 6'd16;
      "(": k = K_SINGLE0 + 6'd17;
      ")": k = K_SINGLE0 + 6'd18;
      "{": k = K_SINGLE0 + 6'd19;
      "}": k = K_SINGLE0 + 6'd20;
      "[": k = K_SINGLE0 + 6'd21;
      "]": k = K_SINGLE0 + 6'd22;
      "#": k = K_SINGLE0 + 6'd23;
      default: k = K_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] pair_kind(logic [7:0] a, logic [7:0] b);
    logic [5:0] k;
    k = K_EOF;
    case ({a, b})
      {"=", "="}: k = K_PAIR0 + 6'd0;
      {"!", "="}: k = K_PAIR0 + 6'd1;
      {"<", "="}: k = K_PAIR0 + 6'd2;
      {">", "="}: k = K_PAIR0 + 6'd3;
      {"+", "+"}: k = K_PAIR0 + 6'd4;
      {"-", "-"}: k = K_PAIR0 + 6'd5;
      {"+", "="}: k = K_PAIR0 + 6'd6;
      {"-", "="}: k = K_PAIR0 + 6'd7;
      {"-", ">"}: k = K_PAIR0 + 6'd8;
      {"&", "&"}: k = K_PAIR0 + 6'd9;
      {"|", "|"}: k = K_PAIR0 + 6'd10;
      {"<", "<"}: k = K_PAIR0 + 6'd11;
      {">", ">"}: k = K_PAIR0 + 6'd12;
      {"#", "#"}: k = K_PAIR0 + 6'd13;
      default: k = K_EOF;
    endcase
    return k;
  endfunction

  // keyword text packed little-endian, first byte in the low bits
  function automatic logic [55:0] pack_kw(logic [55:0] s, int unsigned n);
    logic [55:0] r;
    r = '0;
    for (int i = 0; i < 7; i++) begin
      if (i < n) r[8*i +: 8] = s[8*(n-1-i) +: 8];
    end
    return r;
  endfunction

  function automatic logic [5:0] kw_kind(logic [55:0] buf_v, logic [2:0] len);
    logic [5:0] k;
    k = K_IDENT;
    if      (len == 3'd3 && buf_v == pack_kw("int", 3))     k = K_KW0 + 6'd0;
    else if (len == 3'd6 && buf_v == pack_kw("return", 6))  k = K_KW0 + 6'd1;
    else if (len == 3'd2 && buf_v == pack_kw("if", 2))      k = K_KW0 + 6'd2;
    else if (len == 3'd4 && buf_v == pack_kw("else", 4))    k = K_KW0 + 6'd3;
    else if (len == 3'd5 && buf_v == pack_kw("while", 5))   k = K_KW0 + 6'd4;
    else if (len == 3'd3 && buf_v == pack_kw("for", 3))     k = K_KW0 + 6'd5;
    else if (len == 3'd6 && buf_v == pack_kw("struct", 6))  k = K_KW0 + 6'd6;
    else if (len == 3'd7 && buf_v == pack_kw("typedef", 7)) k = K_KW0 + 6'd7;
    else if (len == 3'd6 && buf_v == pack_kw("extern", 6))  k = K_KW0 + 6'd8;
    else if (len == 3'd6 && buf_v == pack_kw("static", 6))  k = K_KW0 + 6'd9;
    else if (len == 3'd4 && buf_v == pack_kw("char", 4))    k = K_KW0 + 6'd10;
    else if (len == 3'd5 && buf_v == pack_kw("float", 5))   k = K_KW0 + 6'd11;
    else if (len == 3'd6 && buf_v == pack_kw("double", 6))  k = K_KW0 + 6'd12;
    else if (len == 3'd4 && buf_v == pack_kw("void", 4))    k = K_KW0 + 6'd13;
    else if (len == 3'd5 && buf_v == pack_kw("_Bool", 5))   k = K_KW0 + 6'd14;
    return k;
  endfunction
endpackage
`default_nettype wire

// ===== design/cts_core.sv =====
// Scanner core: scan state, position counters and result-record forming.
// Depends on cts_pkg.
`default_nettype none
module cts_core #(
  parameter int unsigned OffsetBits   = cts_pkg::OffsetBitsDef,
  parameter int unsigned PositionBits = cts_pkg::PositionBitsDef,
  parameter int unsigned LengthBits   = cts_pkg::LengthBitsDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    step_i,
  input  wire logic [7:0]              byte_i,
  input  wire logic                    end_i,
  output logic [1:0]                   n_o,
  output logic [5:0]                   kind0_o,
  output logic [PositionBits-1:0]      line0_o,
  output logic [PositionBits-1:0]      col0_o,
  output logic [OffsetBits-1:0]        off0_o,
  output logic [LengthBits-1:0]        len0_o,
  output logic [5:0]                   kind1_o,
  output logic [PositionBits-1:0]      line1_o,
  output logic [PositionBits-1:0]      col1_o,
  output logic [OffsetBits-1:0]        off1_o,
  output logic [LengthBits-1:0]        len1_o
);
  import cts_pkg::*;

  localparam logic [PositionBits-1:0] PosOne = PositionBits'(1);
  localparam logic [PositionBits-1:0] PosMax = '1;
  localparam logic [LengthBits-1:0]   LenMax = '1;
  localparam logic [LengthBits-1:0]   LenOne = LengthBits'(1);

  logic [3:0]              mode_q, mode_d;
  logic [55:0]             kbuf_q, kbuf_d;
  logic [7:0]              pop_q, pop_d;
  logic [PositionBits-1:0] line_q, line_d, col_q, col_d, sline_q, sline_d, scol_q, scol_d;
  logic [OffsetBits-1:0]   off_q, off_d, soff_q, soff_d;
  logic [LengthBits-1:0]   len_q, len_d;

  logic [5:0] ident_k, pk;
  logic       fresh;

  always_comb begin
    ident_k = (len_q == '0 || len_q > LengthBits'(7)) ? K_IDENT : kw_kind(kbuf_q, len_q[2:0]);
    pk = pair_kind(pop_q, byte_i);
  end

  always_comb begin
    mode_d = mode_q; kbuf_d = kbuf_q; pop_d = pop_q;
    line_d = line_q; col_d = col_q; off_d = off_q;
    sline_d = sline_q; scol_d = scol_q; soff_d = soff_q; len_d = len_q;
    n_o = 2'd0; fresh = 1'b0;
    kind0_o = K_EOF; line0_o = sline_q; col0_o = scol_q; off0_o = soff_q; len0_o = len_q;
    kind1_o = K_EOF; line1_o = line_q; col1_o = col_q; off1_o = off_q; len1_o = '0;
    if (end_i) begin
      n_o = 2'd1;
      unique case (mode_q)
        M_IDENT: kind0_o = ident_k;
        M_NUMBER: kind0_o = K_INT;
        M_STRING, M_STR_ESC: kind0_o = K_STRING;
        M_CHAR_OPEN, M_CHAR_ESC, M_CHAR_CLOSE: kind0_o = K_CHAR;
        M_OPER: begin
          kind0_o = single_kind(pop_q);
          len0_o = LenOne;
        end
        default: n_o = 2'd0;
      endcase
      if (n_o == 2'd0) begin
        kind0_o = K_EOF; line0_o = line_q; col0_o = col_q; off0_o = off_q; len0_o = '0;
      end else begin
        kind1_o = K_EOF; line1_o = line_q; col1_o = col_q; off1_o = off_q; len1_o = '0;
      end
      n_o = n_o + 2'd1;
      mode_d = M_IDLE; pop_d = '0; kbuf_d = '0; len_d = '0;
    end else begin
      unique case (mode_q)
        M_IDENT, M_NUMBER: begin
          if (is_digit(byte_i) || (mode_q == M_IDENT && is_alpha(byte_i))) begin
            if (len_q < LengthBits'(7)) kbuf_d[8*len_q[2:0] +: 8] = byte_i;
            if (len_q != LenMax) len_d = len_q + LenOne;
          end else begin
            n_o = 2'd1;
            kind0_o = (mode_q == M_IDENT) ? ident_k : K_INT;
            fresh = 1'b1;
          end
        end
        M_STRING, M_STR_ESC, M_CHAR_OPEN, M_CHAR_ESC: begin
          if (len_q < LengthBits'(7)) kbuf_d[8*len_q[2:0] +: 8] = byte_i;
          if (len_q != LenMax) len_d = len_q + LenOne;
          if (mode_q == M_STRING) begin
            if (byte_i == "\\") mode_d = M_STR_ESC;
            else if (byte_i == "\"") begin
              n_o = 2'd1; kind0_o = K_STRING; len0_o = len_d; mode_d = M_IDLE;
            end
          end else if (mode_q == M_STR_ESC) mode_d = M_STRING;
          else if (mode_q == M_CHAR_OPEN)
            mode_d = (byte_i == "\\") ? M_CHAR_ESC : M_CHAR_CLOSE;
          else mode_d = M_CHAR_CLOSE;
        end
        M_CHAR_CLOSE: begin
          n_o = 2'd1; kind0_o = K_CHAR;
          if (byte_i == "'") begin
            if (len_q < LengthBits'(7)) kbuf_d[8*len_q[2:0] +: 8] = byte_i;
            if (len_q != LenMax) len_d = len_q + LenOne;
            len0_o = len_d; mode_d = M_IDLE;
          end else fresh = 1'b1;
        end
        M_OPER: begin
          if (pk != K_EOF) begin
            n_o = 2'd1; kind0_o = pk; len0_o = LengthBits'(2);
            mode_d = M_IDLE; pop_d = '0;
          end else if (pop_q == "/" && byte_i == "/") begin
            mode_d = M_LINE_COM; pop_d = '0;
          end else if (pop_q == "/" && byte_i == "*") begin
            mode_d = M_BLOCK_COM; pop_d = '0;
          end else begin
            n_o = 2'd1; kind0_o = single_kind(pop_q); len0_o = LenOne; fresh = 1'b1;
          end
        end
        M_LINE_COM: if (byte_i == CH_LF) mode_d = M_IDLE;
        M_BLOCK_COM: if (byte_i == "*") mode_d = M_BLOCK_STAR;
        M_BLOCK_STAR: begin
          if (byte_i == "/") mode_d = M_IDLE;
          else if (byte_i != "*") mode_d = M_BLOCK_COM;
        end
        default: fresh = 1'b1;
      endcase
      if (fresh) begin
        mode_d = M_IDLE; pop_d = '0;
        if (!is_blank(byte_i)) begin
          sline_d = line_q; scol_d = col_q; soff_d = off_q; len_d = LenOne; kbuf_d = '0;
          if (is_alpha(byte_i)) begin
            kbuf_d[7:0] = byte_i; mode_d = M_IDENT;
          end else if (is_digit(byte_i)) mode_d = M_NUMBER;
          else if (byte_i == "\"") mode_d = M_STRING;
          else if (byte_i == "'") mode_d = M_CHAR_OPEN;
          else if (is_op_start(byte_i)) begin
            pop_d = byte_i; mode_d = M_OPER;
          end else begin
            if (n_o == 2'd0) begin
              kind0_o = single_kind(byte_i); line0_o = line_q; col0_o = col_q;
              off0_o = off_q; len0_o = LenOne;
            end else begin
              kind1_o = single_kind(byte_i); len1_o = LenOne;
            end
            n_o = n_o + 2'd1;
          end
        end
      end
      off_d = off_q + OffsetBits'(1);
      if (byte_i == CH_LF) begin
        if (line_q != PosMax) line_d = line_q + PosOne;
        col_d = PosOne;
      end else if (col_q != PosMax) col_d = col_q + PosOne;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE; kbuf_q <= '0; pop_q <= '0;
      line_q <= PosOne; col_q <= PosOne; off_q <= '0;
      sline_q <= PosOne; scol_q <= PosOne; soff_q <= '0; len_q <= '0;
    end else if (step_i) begin
      mode_q <= mode_d; kbuf_q <= kbuf_d; pop_q <= pop_d;
      line_q <= line_d; col_q <= col_d; off_q <= off_d;
      sline_q <= sline_d; scol_q <= scol_d; soff_q <= soff_d; len_q <= len_d;
    end
  end
endmodule
`default_nettype wire

// ===== design/cts_out_buf.sv =====
// Result buffer: holds up to two records and hands them out one per item.
// Depends on cts_pkg for default widths.
`default_nettype none
module cts_out_buf #(
  parameter int unsigned OffsetBits   = cts_pkg::OffsetBitsDef,
  parameter int unsigned PositionBits = cts_pkg::PositionBitsDef,
  parameter int unsigned LengthBits   = cts_pkg::LengthBitsDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  load_i,
  input  wire logic [1:0]            n_i,
  input  wire logic [5:0]            kind0_i,
  input  wire logic [PositionBits-1:0] line0_i,
  input  wire logic [PositionBits-1:0] col0_i,
  input  wire logic [OffsetBits-1:0] off0_i,
  input  wire logic [LengthBits-1:0] len0_i,
  input  wire logic [5:0]            kind1_i,
  input  wire logic [PositionBits-1:0] line1_i,
  input  wire logic [PositionBits-1:0] col1_i,
  input  wire logic [OffsetBits-1:0] off1_i,
  input  wire logic [LengthBits-1:0] len1_i,
  output logic                       free_o,
  output logic                       valid_o,
  input  wire logic                  ready_i,
  output logic [5:0]                 kind_o,
  output logic [PositionBits-1:0]    line_o,
  output logic [PositionBits-1:0]    col_o,
  output logic [OffsetBits-1:0]      off_o,
  output logic [LengthBits-1:0]      len_o,
  output logic                       last_o
);
  localparam int unsigned RecBits = 6 + 2*PositionBits + OffsetBits + LengthBits;
  logic [1:0]         cnt_q, cnt_d;
  logic [RecBits-1:0] r0_q, r1_q;
  logic               pop;

  assign valid_o = cnt_q != 2'd0;
  assign pop = valid_o && ready_i;
  assign free_o = cnt_q == 2'd0 || (cnt_q == 2'd1 && pop);
  assign {kind_o, line_o, col_o, off_o, len_o} = r0_q;
  assign last_o = cnt_q == 2'd1;

  always_comb begin
    cnt_d = cnt_q;
    if (pop) cnt_d = cnt_q - 2'd1;
    if (load_i) cnt_d = n_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= 2'd0;
    else cnt_q <= cnt_d;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      r0_q <= {kind0_i, line0_i, col0_i, off0_i, len0_i};
      r1_q <= {kind1_i, line1_i, col1_i, off1_i, len1_i};
    end else if (pop) begin
      r0_q <= r1_q;
    end
  end
endmodule
`default_nettype wire

// ===== design/c_token_scanner.sv =====
// Top level of the streaming C token scanner.
// Depends on cts_pkg, cts_core and cts_out_buf.
//
// Usage: source bytes enter on the in channel (source_byte_i, end_of_input_i)
// with valid/ready; token records leave on the out channel with valid/ready.
// Each input byte updates scan state in the cycle it is accepted; the records
// it causes (zero, one or two) appear in the result buffer the next cycle.
// Throughput is one byte per cycle while each byte gives at most one record and
// the receiver takes every record; a byte giving two records holds the input
// back while the single-record output port drains the buffer.
// The end marker flushes a pending token and then gives EOF, flagged last.
// Reset clears scan mode and the buffer, and sets line and column to one.
// When the receiver stalls, records wait in the buffer and in_ready_o stays
// low while the buffer holds a record that is not taken in that cycle,
// whatever the next byte would give; nothing is lost.
`default_nettype none
module c_token_scanner #(
  parameter int unsigned OffsetBits   = cts_pkg::OffsetBitsDef,
  parameter int unsigned PositionBits = cts_pkg::PositionBitsDef,
  parameter int unsigned LengthBits   = cts_pkg::LengthBitsDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [7:0]              source_byte_i,
  input  wire logic                    end_of_input_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [5:0]                   token_kind_o,
  output logic [PositionBits-1:0]      start_line_o,
  output logic [PositionBits-1:0]      start_column_o,
  output logic [OffsetBits-1:0]        start_offset_o,
  output logic [LengthBits-1:0]        token_length_o,
  output logic                         last_result_o
);
  logic [1:0]              n;
  logic [5:0]              k0, k1;
  logic [PositionBits-1:0] l0, c0, l1, c1;
  logic [OffsetBits-1:0]   o0, o1;
  logic [LengthBits-1:0]   n0, n1;
  logic                    step;

  assign step = in_valid_i && in_ready_o;

  cts_core #(.OffsetBits(OffsetBits), .PositionBits(PositionBits),
             .LengthBits(LengthBits)) u_core (
    .clk_i, .rst_ni, .step_i(step), .byte_i(source_byte_i), .end_i(end_of_input_i),
    .n_o(n), .kind0_o(k0), .line0_o(l0), .col0_o(c0), .off0_o(o0), .len0_o(n0),
    .kind1_o(k1), .line1_o(l1), .col1_o(c1), .off1_o(o1), .len1_o(n1)
  );

  cts_out_buf #(.OffsetBits(OffsetBits), .PositionBits(PositionBits),
                .LengthBits(LengthBits)) u_obuf (
    .clk_i, .rst_ni, .load_i(step && n != 2'd0), .n_i(n),
    .kind0_i(k0), .line0_i(l0), .col0_i(c0), .off0_i(o0), .len0_i(n0),
    .kind1_i(k1), .line1_i(l1), .col1_i(c1), .off1_i(o1), .len1_i(n1),
    .free_o(in_ready_o), .valid_o(out_valid_o), .ready_i(out_ready_i),
    .kind_o(token_kind_o), .line_o(start_line_o), .col_o(start_column_o),
    .off_o(start_offset_o), .len_o(token_length_o), .last_o(last_result_o)
  );
endmodule
`default_nettype wire

// ===== design/cts_checker.sv =====
// Port-level checker for the token scanner, bound to the top level.
// Depends on cts_pkg and c_token_scanner_assert.svh.
`default_nettype none
`include "c_token_scanner_assert.svh"
module cts_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       end_of_input_i,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [5:0] token_kind_o,
  input wire logic       last_result_o
);
  import cts_pkg::*;
  `CTS_ASSERT_NEXT(a_eof_out, clk_i, rst_ni, in_valid_i && in_ready_o && end_of_input_i, out_valid_o)
  `CTS_ASSERT_IMPL(a_eof_last, clk_i, rst_ni, out_valid_o && token_kind_o == K_EOF, last_result_o)
  `CTS_ASSERT_IMPL(a_idle_ready, clk_i, rst_ni, !out_valid_o, in_ready_o)
  `CTS_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(token_kind_o))
endmodule

bind c_token_scanner cts_checker u_cts_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .end_of_input_i, .out_valid_o,
  .out_ready_i, .token_kind_o, .last_result_o
);
`default_nettype wire
